@@ src/rrqs_pkg.sv @@
// ----------------------------------------------------------------------------
// rrqs_pkg
// Shared types and constants of the round robin quantum scheduler.
// ----------------------------------------------------------------------------
package rrqs_pkg;

    localparam int MAX_JOBS    = 16;
    localparam int CNT_W       = $clog2(MAX_JOBS + 1);
    localparam int ID_W        = 8;
    localparam int TIME_W      = 16;
    localparam int JOBS_LEFT_W = 5;

    localparam logic [TIME_W-1:0] QUANTUM_RESET = TIME_W'(3);

    // Input actions.
    localparam logic ACT_ADD   = 1'b0;
    localparam logic ACT_SLICE = 1'b1;

    // Result status codes.
    localparam logic [1:0] ST_ADDED    = 2'd0;
    localparam logic [1:0] ST_REJECTED = 2'd1;
    localparam logic [1:0] ST_SERVED   = 2'd2;
    localparam logic [1:0] ST_IDLE     = 2'd3;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] remaining;
    } t_job;

    typedef struct packed {
        logic shift;
        logic load;
    } t_cell_ctl;

endpackage

@@ src/rrqs_cell.sv @@
// ----------------------------------------------------------------------------
// rrqs_cell
// One queue slot: takes its right neighbor's job on a shift, or a new job on a load.
// ----------------------------------------------------------------------------
module rrqs_cell
    import rrqs_pkg::*;
(
    input  logic      i_clk,
    input  t_cell_ctl i_ctl,
    input  t_job      i_next,
    input  t_job      i_load,
    output t_job      o_job
);

    t_job r_job;
    t_job n_job;

    // A load beats a shift: the requeued head lands in the cell that the
    // shift would otherwise fill from its neighbor.
    always_comb begin
        n_job = r_job;
        if (i_ctl.load) begin
            n_job = i_load;
        end else if (i_ctl.shift) begin
            n_job = i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job <= n_job;
    end

    assign o_job = r_job;

endmodule

@@ src/round_robin_quantum_scheduler.sv @@
// ----------------------------------------------------------------------------
// round_robin_quantum_scheduler
// Round robin job queue with a programmable time quantum.
// ----------------------------------------------------------------------------
// Usage: an item (action, job_id, burst_time) is taken at a clock edge where
// start is high and busy is low. busy stays low, so a new item may be given
// in every cycle. An add puts the job at the tail of the queue; a slice
// serves the head job for one quantum and either retires it or sends it to
// the tail with the quantum taken off.
// Each item yields one result beat in the cycle after it is taken, shown for a
// single cycle with o_strobe high. The receiver cannot stall; results must be
// captured when the strobe is seen. Throughput is one item per cycle.
// The queue is a row of cells with the head in cell 0; a slice shifts every
// cell toward the head at once, and one compare and subtract on cell 0
// sets the cycle time.
// i_cfg_we writes the quantum; write it only while no result is pending.
// A synchronous reset empties the queue and sets the quantum to 3.
// ----------------------------------------------------------------------------
module round_robin_quantum_scheduler
    import rrqs_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic                   i_action,
    input  logic [ID_W-1:0]        i_job_id,
    input  logic [TIME_W-1:0]      i_burst_time,
    input  logic                   i_cfg_we,
    input  logic [TIME_W-1:0]      i_cfg_wdata,
    output logic                   o_strobe,
    output logic [1:0]             o_status,
    output logic [ID_W-1:0]        o_served_id,
    output logic [TIME_W-1:0]      o_remaining_after,
    output logic                   o_completed,
    output logic [JOBS_LEFT_W-1:0] o_jobs_left
);

    logic [TIME_W-1:0] r_quantum;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic              r_strobe;

    t_job              cell_job [MAX_JOBS+1];
    t_cell_ctl         cell_ctl [MAX_JOBS];
    t_job              load_job;
    t_job              head;
    logic [CNT_W-1:0]  load_idx;
    logic              accept;
    logic              is_add;
    logic              full;
    logic              empty;
    logic              fits;
    logic              add_ok;
    logic              slice_ok;
    logic              requeue;
    logic              do_load;
    logic [TIME_W-1:0] left;

    assign busy     = 1'b0;
    assign accept   = start & ~busy;
    assign is_add   = (i_action == ACT_ADD);
    assign full     = (r_count == CNT_W'(MAX_JOBS));
    assign empty    = (r_count == '0);
    assign head     = cell_job[0];
    assign fits     = (head.remaining <= r_quantum);
    assign left     = head.remaining - r_quantum;
    assign add_ok   = accept & is_add & ~full;
    assign slice_ok = accept & ~is_add & ~empty;
    assign requeue  = slice_ok & ~fits;
    assign do_load  = add_ok | requeue;

    // On a requeue the shift has already moved the queue up by one, so the
    // tail slot is one below the count.
    assign load_idx = add_ok ? r_count : (r_count - CNT_W'(1));

    always_comb begin
        if (add_ok) begin
            load_job.id        = i_job_id;
            load_job.remaining = i_burst_time;
        end else begin
            load_job.id        = head.id;
            load_job.remaining = left;
        end
    end

    assign cell_job[MAX_JOBS] = '0;

    for (genvar i = 0; i < MAX_JOBS; i++) begin : g_cell
        assign cell_ctl[i].shift = slice_ok;
        assign cell_ctl[i].load  = do_load & (load_idx == CNT_W'(i));

        rrqs_cell u_cell (
            .i_clk  (i_clk),
            .i_ctl  (cell_ctl[i]),
            .i_next (cell_job[i+1]),
            .i_load (load_job),
            .o_job  (cell_job[i])
        );
    end

    always_comb begin
        n_count = r_count;
        if (add_ok) begin
            n_count = r_count + CNT_W'(1);
        end else if (slice_ok && fits) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quantum <= QUANTUM_RESET;
            r_count   <= '0;
            r_strobe  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_quantum <= i_cfg_wdata;
            end
            r_count  <= n_count;
            r_strobe <= accept;
        end
    end

    // Result beat fields.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            o_served_id       <= '0;
            o_remaining_after <= '0;
            o_completed       <= 1'b0;
            o_jobs_left       <= JOBS_LEFT_W'(n_count);
            if (is_add) begin
                o_status <= full ? ST_REJECTED : ST_ADDED;
            end else if (empty) begin
                o_status <= ST_IDLE;
            end else begin
                o_status          <= ST_SERVED;
                o_served_id       <= head.id;
                o_remaining_after <= fits ? '0 : left;
                o_completed       <= fits;
            end
        end
    end

    assign o_strobe = r_strobe;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_JOBS))
        else $error("job count exceeds queue depth");

    a_strobe_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_strobe)
        else $error("accepted item produced no result beat");

    a_done_served: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_completed) |-> (o_status == ST_SERVED))
        else $error("completion flagged on a non-slice result");

    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status == ST_IDLE) |-> (o_jobs_left == '0))
        else $error("idle result reported with jobs queued");

    a_reject_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status == ST_REJECTED) |-> (r_count == CNT_W'(MAX_JOBS)))
        else $error("add rejected while queue not full");
`endif

endmodule

@@ tb/sv/tb_round_robin_quantum_scheduler.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_round_robin_quantum_scheduler
// Self-checking bench for the round robin quantum scheduler. It drives add
// and slice commands with random gaps and predicts every result beat with a
// queue model of the job ring. Each field of each beat is compared in order.
// The quantum is reprogrammed between phases, covering zero, one and all ones.
// ----------------------------------------------------------------------------
module tb_round_robin_quantum_scheduler
    import rrqs_pkg::*;
();

    localparam int IDLE_PCT      = 11;
    localparam int STALL_LIMIT   = 1000;
    localparam int SETTLE_CYCLES = 3;
    localparam int PHASE_ITEMS   = 280;
    localparam int BLOCK_ITEMS   = 40;

    typedef struct packed {
        logic [1:0]             status;
        logic [ID_W-1:0]        served_id;
        logic [TIME_W-1:0]      remaining_after;
        logic                   completed;
        logic [JOBS_LEFT_W-1:0] jobs_left;
    } t_sched_result;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   start;
    logic                   busy;
    logic                   i_action;
    logic [ID_W-1:0]        i_job_id;
    logic [TIME_W-1:0]      i_burst_time;
    logic                   i_cfg_we;
    logic [TIME_W-1:0]      i_cfg_wdata;
    logic                   o_strobe;
    logic [1:0]             o_status;
    logic [ID_W-1:0]        o_served_id;
    logic [TIME_W-1:0]      o_remaining_after;
    logic                   o_completed;
    logic [JOBS_LEFT_W-1:0] o_jobs_left;

    // Scheduler state as the bench sees it: the front of the queue is the head job.
    t_job              job_ring[$];
    logic [TIME_W-1:0] quantum_reg;
    t_sched_result     pending_results[$];

    bit gaps_on;
    int stall_cycles;
    int n_errors;
    int n_items;
    int n_results;
    int n_retired;
    int n_rotated;
    int n_rejected;
    int n_idle;
    int n_quanta;

    round_robin_quantum_scheduler dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_sched_result schedule_step(input logic act,
                                                    input logic [ID_W-1:0] new_id,
                                                    input logic [TIME_W-1:0] new_burst);
        t_sched_result r;
        t_job          job;
        r = '0;
        if (act == ACT_ADD) begin
            if (job_ring.size() >= MAX_JOBS) begin
                r.status = ST_REJECTED;
                n_rejected++;
            end else begin
                job.id        = new_id;
                job.remaining = new_burst;
                job_ring.push_back(job);
                r.status = ST_ADDED;
            end
        end else if (job_ring.size() == 0) begin
            r.status = ST_IDLE;
            n_idle++;
        end else begin
            job         = job_ring.pop_front();
            r.status    = ST_SERVED;
            r.served_id = job.id;
            if (job.remaining <= quantum_reg) begin
                r.completed = 1'b1;
                n_retired++;
            end else begin
                // With a full ring the tail slot is the head slot, which a queue
                // model covers by popping before pushing.
                job.remaining     = job.remaining - quantum_reg;
                r.remaining_after = job.remaining;
                job_ring.push_back(job);
                n_rotated++;
            end
        end
        r.jobs_left = JOBS_LEFT_W'(job_ring.size());
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] expv,
                                        input logic [31:0] got);
        if (got !== expv) begin
            $error("%s mismatch: expected %0h, got %0h", name, expv, got);
            n_errors++;
        end
    endfunction

    // Enters and leaves just after a falling edge. start is only lowered for a
    // gap, so back-to-back beats never see it dropped and raised in one step.
    task automatic send_item(input logic act, input logic [ID_W-1:0] new_id,
                             input logic [TIME_W-1:0] new_burst);
        while (gaps_on && $urandom_range(99) < IDLE_PCT) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start        <= 1'b1;
        i_action     <= act;
        i_job_id     <= new_id;
        i_burst_time <= new_burst;
        do begin
            @(posedge i_clk);
        end while (busy);
        pending_results.push_back(schedule_step(act, new_id, new_burst));
        n_items++;
        @(negedge i_clk);
    endtask

    task automatic wait_drain();
        start <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_quantum(input logic [TIME_W-1:0] q);
        wait_drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= q;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        quantum_reg = q;
        n_quanta++;
    endtask

    // Bursts are mostly a few quanta long so jobs both rotate and retire.
    task automatic send_random(input int add_pct);
        logic [TIME_W-1:0] burst;
        int unsigned       span;
        span = (quantum_reg == 0) ? 4 : quantum_reg * 4;
        if (span > 65535) span = 65535;
        if ($urandom_range(99) < 25) burst = TIME_W'($urandom);
        else burst = TIME_W'($urandom_range(0, span));
        send_item(($urandom_range(99) < add_pct) ? ACT_ADD : ACT_SLICE,
                  ID_W'($urandom), burst);
    endtask

    task automatic test_directed_edges();
        int k;
        send_item(ACT_SLICE, 8'h00, 16'h0000);
        send_item(ACT_ADD, 8'hFF, 16'hFFFF);
        send_item(ACT_ADD, 8'h00, 16'h0000);
        send_item(ACT_ADD, 8'hA5, 16'h0003);
        send_item(ACT_ADD, 8'h5A, 16'h0004);
        for (k = 4; k < MAX_JOBS; k++) begin
            send_item(ACT_ADD, ID_W'(k), TIME_W'($urandom_range(0, 12)));
        end
        send_item(ACT_ADD, 8'h77, 16'h1234);
        // Full ring: the long job goes back in place, then the zero-length job,
        // the one equal to the quantum, and one just above it.
        send_item(ACT_SLICE, 8'hFF, 16'hFFFF);
        send_item(ACT_SLICE, 8'h00, 16'h0000);
        send_item(ACT_SLICE, 8'hFF, 16'hFFFF);
        send_item(ACT_SLICE, 8'h00, 16'h0000);
    endtask

    task automatic test_quantum_extremes();
        logic [TIME_W-1:0] settings[4];
        settings[0] = '0;
        settings[1] = TIME_W'(1);
        settings[2] = '1;
        settings[3] = TIME_W'($urandom_range(2, 1000));
        foreach (settings[s]) begin
            write_quantum(settings[s]);
            repeat (BLOCK_ITEMS) send_random(50);
        end
    endtask

    task automatic test_random_traffic();
        int ph;
        int n;
        int add_pct;
        for (ph = 0; ph < 6; ph++) begin
            case (ph)
                0:       write_quantum(TIME_W'(2));
                1:       write_quantum(TIME_W'($urandom_range(1, 16)));
                2:       write_quantum(TIME_W'($urandom_range(1, 300)));
                3:       write_quantum(TIME_W'(1));
                4:       write_quantum(TIME_W'($urandom_range(1, 65535)));
                default: write_quantum(TIME_W'(5));
            endcase
            gaps_on = (ph != 3);
            for (n = 0; n < PHASE_ITEMS; n++) begin
                // Swing the add rate so the ring runs both full and empty.
                case ((n / BLOCK_ITEMS) % 3)
                    0:       add_pct = 80;
                    1:       add_pct = 25;
                    default: add_pct = 55;
                endcase
                send_random(add_pct);
            end
        end
        gaps_on = 1'b1;
    endtask

    always @(posedge i_clk) begin
        t_sched_result exp_r;
        if (i_rst_n && o_strobe) begin
            if (pending_results.size() == 0) begin
                $error("result beat with no command outstanding");
                n_errors++;
            end else begin
                exp_r = pending_results.pop_front();
                n_results++;
                check_field("status", exp_r.status, o_status);
                check_field("served_id", exp_r.served_id, o_served_id);
                check_field("remaining_after", exp_r.remaining_after, o_remaining_after);
                check_field("completed", exp_r.completed, o_completed);
                check_field("jobs_left", exp_r.jobs_left, o_jobs_left);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        i_rst_n      <= 1'b0;
        start        <= 1'b0;
        i_action     <= ACT_ADD;
        i_job_id     <= '0;
        i_burst_time <= '0;
        i_cfg_we     <= 1'b0;
        i_cfg_wdata  <= '0;
        stall_cycles = 0;
        n_errors     = 0;
        n_items      = 0;
        n_results    = 0;
        n_retired    = 0;
        n_rotated    = 0;
        n_rejected   = 0;
        n_idle       = 0;
        n_quanta     = 1;
        gaps_on      = 1'b1;
        quantum_reg  = QUANTUM_RESET;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed_edges();
        test_quantum_extremes();
        test_random_traffic();
        wait_drain();

        if (pending_results.size() != 0) begin
            $error("%0d result beats never arrived", pending_results.size());
            n_errors++;
        end
        $display("Ran %0d commands under %0d quantum settings; %0d result beats checked.",
                 n_items, n_quanta, n_results);
        $display("Jobs retired %0d, rotated %0d; adds refused %0d; empty slices %0d.",
                 n_retired, n_rotated, n_rejected, n_idle);
        if (n_errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
